FILE: rtl/core/xrg_pkg.sv
// Package with constants and types for the xoshiro256** random generator.
`timescale 1ns / 1ps

package xrg_pkg;

  localparam logic [63:0] SM_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] SM_MUL1  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] SM_MUL2  = 64'h94D049BB133111EB;

  localparam logic [1:0] MODE_RAW  = 2'd0;
  localparam logic [1:0] MODE_HI32 = 2'd1;
  localparam logic [1:0] MODE_FRAC = 2'd2;
  localparam logic [1:0] MODE_INT  = 2'd3;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_BAD_ARG = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SEED = 6'b000010,
    ST_DRAW = 6'b000100,
    ST_DIV1 = 6'b001000,
    ST_DIV2 = 6'b010000,
    ST_OUT  = 6'b100000
  } xrg_state_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned k);
    rotl64 = (x << k) | (x >> (64 - k));
  endfunction

  function automatic logic [63:0] mix30(input logic [63:0] x);
    mix30 = x ^ (x >> 30);
  endfunction

endpackage

FILE: rtl/core/xoshiro_random_generator_top.sv
// Top level of the xoshiro256** random generator with a shared multiplier and serial divider.
//
//  Channel | Direction | Handshake         | Payload
//  in      | input     | in_tvalid/tready  | tuser: mode; tdata: range_min, range_max
//  out     | output    | out_tvalid/tready | tdata: value; tuser: status
//  cfg     | input     | cfg_wr_en         | cfg_wr_data: seed
//
// Modes 0 to 2 go through accept, one draw and result.
// Mode 3 draws again after each rejected word and runs the 64-step serial divider twice
// (once for the rejection threshold, once for the final remainder).
// In mode 3, a bad argument or a span of one needs no draw, and the full span no divider.
// After reset and after every seed write, the block expands the seed through one shared
// 32x32 multiplier and accepts no request meanwhile.
// A result waits in the output register until taken; no new request is accepted until then.
`timescale 1ns / 1ps

module xoshiro_random_generator_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [127:0]  in_tdata,     // [63:0] range_min, [127:64] range_max
  input  logic [1:0]    in_tuser,     // [1:0] mode
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata,    // [63:0] value
  output logic          out_tuser,    // [0] status
  input  logic          cfg_wr_en,
  input  logic [63:0]   cfg_wr_data
);
  import xrg_pkg::*;

  xrg_state_t  state_r, state_nxt;
  logic [63:0] gs_r [4];
  logic [63:0] gs_nxt [4];
  logic [63:0] x_r, x_nxt, z_r, z_nxt, acc_r, acc_nxt;
  logic [1:0]  ph_r, ph_nxt, widx_r, widx_nxt, mode_r, mode_nxt;
  logic        pass_r, pass_nxt;
  logic [63:0] lo_r, lo_nxt, span_r, span_nxt, extra_r, extra_nxt;
  logic [63:0] dvd_r, dvd_nxt, rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] val_r, val_nxt;
  logic        sts_r, sts_nxt;

  // Shared multiplier operands and product.
  logic [63:0] mul_b, mul_res;
  logic [31:0] mul_x, mul_y;
  logic [63:0] prod;

  // Draw logic.
  logic [63:0] s1x5, rot7, word, n0, n1, n2, n3;
  logic        reject;

  // Divider step.
  logic [64:0] div_sh, div_diff;
  logic [63:0] div_rem;

  logic [63:0] req_lo, req_hi, req_span;

  assign mul_b = pass_r ? SM_MUL2 : SM_MUL1;
  always_comb begin
    unique case (ph_r)
      2'd0:    begin mul_x = z_r[31:0];  mul_y = mul_b[31:0];  end
      2'd1:    begin mul_x = z_r[31:0];  mul_y = mul_b[63:32]; end
      default: begin mul_x = z_r[63:32]; mul_y = mul_b[31:0];  end
    endcase
  end
  assign prod    = {32'd0, mul_x} * {32'd0, mul_y};
  assign mul_res = acc_r + {prod[31:0], 32'd0};

  assign s1x5 = gs_r[1] + (gs_r[1] << 2);
  assign rot7 = rotl64(s1x5, 7);
  assign word = rot7 + (rot7 << 3);
  assign n2   = gs_r[2] ^ gs_r[0];
  assign n3   = gs_r[3] ^ gs_r[1];
  assign n1   = gs_r[1] ^ n2;
  assign n0   = gs_r[0] ^ n3;

  // A span that divides 2^64 rejects nothing; otherwise reject from 2^64 - extra upward.
  assign reject = (extra_r != span_r) && (word >= (64'd0 - extra_r));

  assign div_sh   = {rem_r, dvd_r[63]};
  assign div_diff = div_sh - {1'b0, span_r};
  assign div_rem  = div_diff[64] ? div_sh[63:0] : div_diff[63:0];

  assign req_lo   = in_tdata[63:0];
  assign req_hi   = in_tdata[127:64];
  assign req_span = req_hi - req_lo + 64'd1;

  always_comb begin
    state_nxt = state_r;
    for (int i = 0; i < 4; i++) gs_nxt[i] = gs_r[i];
    x_nxt = x_r;  z_nxt = z_r;  acc_nxt = acc_r;
    ph_nxt = ph_r;  pass_nxt = pass_r;  widx_nxt = widx_r;
    mode_nxt = mode_r;  lo_nxt = lo_r;  span_nxt = span_r;  extra_nxt = extra_r;
    dvd_nxt = dvd_r;  rem_nxt = rem_r;  cnt_nxt = cnt_r;
    val_nxt = val_r;  sts_nxt = sts_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          mode_nxt = in_tuser;
          lo_nxt   = req_lo;
          span_nxt = req_span;
          sts_nxt  = STATUS_OK;
          if (in_tuser != MODE_INT) begin
            state_nxt = ST_DRAW;
          end else if ($signed(req_lo) > $signed(req_hi)) begin
            val_nxt   = 64'd0;
            sts_nxt   = STATUS_BAD_ARG;
            state_nxt = ST_OUT;
          end else if (req_span == 64'd1) begin
            val_nxt   = req_lo;
            state_nxt = ST_OUT;
          end else if (req_span == 64'd0) begin
            state_nxt = ST_DRAW;
          end else begin
            dvd_nxt   = '1;
            rem_nxt   = 64'd0;
            cnt_nxt   = 6'd0;
            state_nxt = ST_DIV1;
          end
        end
      end
      ST_SEED: begin
        if (ph_r != 2'd2) begin
          acc_nxt = (ph_r == 2'd0) ? prod : mul_res;
          ph_nxt  = ph_r + 2'd1;
        end else begin
          ph_nxt = 2'd0;
          if (!pass_r) begin
            z_nxt    = mul_res ^ (mul_res >> 27);
            pass_nxt = 1'b1;
          end else begin
            gs_nxt[widx_r] = mul_res ^ (mul_res >> 31);
            pass_nxt       = 1'b0;
            widx_nxt       = widx_r + 2'd1;
            x_nxt          = x_r + SM_GAMMA;
            z_nxt          = mix30(x_r + SM_GAMMA);
            if (widx_r == 2'd3) state_nxt = ST_IDLE;
          end
        end
      end
      ST_DRAW: begin
        gs_nxt[0] = n0;
        gs_nxt[1] = n1;
        gs_nxt[2] = n2 ^ (gs_r[1] << 17);
        gs_nxt[3] = rotl64(n3, 45);
        unique case (mode_r)
          MODE_RAW:  begin val_nxt = word;                  state_nxt = ST_OUT; end
          MODE_HI32: begin val_nxt = {32'd0, word[63:32]};  state_nxt = ST_OUT; end
          MODE_FRAC: begin val_nxt = {11'd0, word[63:11]};  state_nxt = ST_OUT; end
          default: begin
            if (span_r == 64'd0) begin
              val_nxt   = lo_r + word;
              state_nxt = ST_OUT;
            end else if (!reject) begin
              dvd_nxt   = word;
              rem_nxt   = 64'd0;
              cnt_nxt   = 6'd0;
              state_nxt = ST_DIV2;
            end
          end
        endcase
      end
      ST_DIV1: begin
        rem_nxt = div_rem;
        dvd_nxt = dvd_r << 1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          extra_nxt = div_rem + 64'd1;
          state_nxt = ST_DRAW;
        end
      end
      ST_DIV2: begin
        rem_nxt = div_rem;
        dvd_nxt = dvd_r << 1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          val_nxt   = lo_r + div_rem;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    // A seed write restarts the expansion from the new value.
    if (cfg_wr_en) begin
      state_nxt = ST_SEED;
      x_nxt     = cfg_wr_data + SM_GAMMA;
      z_nxt     = mix30(cfg_wr_data + SM_GAMMA);
      ph_nxt    = 2'd0;
      pass_nxt  = 1'b0;
      widx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SEED;
      x_r     <= SM_GAMMA;
      z_r     <= mix30(SM_GAMMA);
      ph_r    <= 2'd0;
      pass_r  <= 1'b0;
      widx_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      x_r     <= x_nxt;
      z_r     <= z_nxt;
      ph_r    <= ph_nxt;
      pass_r  <= pass_nxt;
      widx_r  <= widx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) gs_r[i] <= gs_nxt[i];
    acc_r   <= acc_nxt;
    mode_r  <= mode_nxt;
    lo_r    <= lo_nxt;
    span_r  <= span_nxt;
    extra_r <= extra_nxt;
    dvd_r   <= dvd_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    val_r   <= val_nxt;
    sts_r   <= sts_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE) && !cfg_wr_en;
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = val_r;
  assign out_tuser  = sts_r;

endmodule

FILE: rtl/core/xrg_checker.sv
// Port-level checker for the xoshiro256** random generator, bound to the top level.
`timescale 1ns / 1ps

module xrg_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [63:0]  out_tdata,
  input logic         out_tuser,
  input logic         cfg_wr_en
);

  // The block handles one request at a time, so it never takes one while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("request accepted while a result is pending");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("ready after an accepted request");

  a_seed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> !in_tready && !out_tvalid)
    else $error("seed expansion did not block the channels");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == 64'd0))
    else $error("bad-argument result with a nonzero value");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n || cfg_wr_en)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind xoshiro_random_generator_top xrg_checker u_xrg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .cfg_wr_en  (cfg_wr_en)
);

FILE: sim/tb_xoshiro_random_generator_top.sv
// Self-checking testbench for the xoshiro256** random generator top level.
`timescale 1ns / 1ps

import xrg_pkg::*;

class draw_scoreboard;
  logic [63:0] gen_word [4];
  logic [63:0] want_value [$];
  logic        want_status [$];
  int          mismatches;
  int          checked;

  function logic [63:0] rol(logic [63:0] x, int k);
    return (x << k) | (x >> (64 - k));
  endfunction

  function void load_seed(logic [63:0] s);
    logic [63:0] x;
    logic [63:0] z;
    x = s;
    for (int i = 0; i < 4; i++) begin
      x = x + 64'h9E3779B97F4A7C15;
      z = x;
      z = (z ^ (z >> 30)) * 64'hBF58476D1CE4E5B9;
      z = (z ^ (z >> 27)) * 64'h94D049BB133111EB;
      gen_word[i] = z ^ (z >> 31);
    end
  endfunction

  function logic [63:0] next_word();
    logic [63:0] res;
    logic [63:0] t;
    res = rol(gen_word[1] * 64'd5, 7) * 64'd9;
    t = gen_word[1] << 17;
    gen_word[2] ^= gen_word[0];
    gen_word[3] ^= gen_word[1];
    gen_word[1] ^= gen_word[2];
    gen_word[0] ^= gen_word[3];
    gen_word[2] ^= t;
    gen_word[3] = rol(gen_word[3], 45);
    return res;
  endfunction

  // Computes the expected result of one accepted request.
  function void note_request(logic [1:0] mode, logic [63:0] lo, logic [63:0] hi);
    logic [63:0] span;
    logic [63:0] extra;
    logic [63:0] w;
    logic [63:0] v;
    logic        st;
    st = STATUS_OK;
    v = '0;
    case (mode)
      MODE_RAW:  v = next_word();
      MODE_HI32: v = next_word() >> 32;
      MODE_FRAC: v = next_word() >> 11;
      default: begin
        if ((lo ^ 64'h8000000000000000) > (hi ^ 64'h8000000000000000)) begin
          st = STATUS_BAD_ARG;
        end else begin
          span = hi - lo + 64'd1;
          if (span == 64'd0) begin
            v = lo + next_word();
          end else if (span == 64'd1) begin
            v = lo;
          end else begin
            extra = ({64{1'b1}} % span) + 64'd1;
            if (extra == span) begin
              w = next_word();
            end else begin
              // Words from the biased top of the space are thrown away.
              do w = next_word(); while (w >= (64'd0 - extra));
            end
            v = lo + (w % span);
          end
        end
      end
    endcase
    want_value.push_back(v);
    want_status.push_back(st);
  endfunction

  function void check_result(logic [63:0] value, logic status);
    if (want_value.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result value=%h status=%b", value, status);
      return;
    end
    checked++;
    if (want_value[0] !== value || want_status[0] !== status) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected value=%h status=%b, got value=%h status=%b",
                 want_value[0], want_status[0], value, status);
    end
    void'(want_value.pop_front());
    void'(want_status.pop_front());
  endfunction
endclass

module tb_xoshiro_random_generator_top;
  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic         out_tuser;
  logic         cfg_wr_en;
  logic [63:0]  cfg_wr_data;

  draw_scoreboard sb;
  longint cycles;
  bit     timed_out;
  int     sent;
  bit     steady;

  localparam longint CYCLE_LIMIT = 3000000;

  xoshiro_random_generator_top uut (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // Result side: random stalls, with long stretches of none.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  initial begin
    int gap;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_tvalid && out_tready) out_tready = 1'b0;
      if (!out_tready) begin
        gap = steady ? 0 : int'($urandom_range(0, 14));
        repeat (gap) @(negedge clk);
        out_tready = 1'b1;
      end
    end
  end

  function logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic send_request(logic [1:0] mode, logic [63:0] lo, logic [63:0] hi);
    int gap;
    gap = steady ? 0 : int'($urandom_range(0, 14));
    repeat (gap) @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = {hi, lo};
    do @(posedge clk); while (!in_tready);
    sb.note_request(mode, lo, hi);
    sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (sb.want_value.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_seed(logic [63:0] s);
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = s;
    sb.load_seed(s);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic random_request();
    logic [1:0]  mode;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] w;
    mode = 2'($urandom_range(0, 3));
    lo = rand64();
    hi = rand64();
    if (mode == MODE_INT) begin
      case ($urandom_range(0, 5))
        0: hi = lo + 64'($urandom_range(0, 20));
        1: hi = lo + (64'd1 << $urandom_range(1, 63)) - 64'd1;
        2: begin
          lo = {{33{lo[63]}}, lo[30:0]};
          hi = lo + 64'($urandom_range(0, 1000));
        end
        3: begin
          // Spans just above a half trigger frequent rejection.
          w = 64'h8000000000000000 + 64'($urandom_range(1, 1 << 20));
          hi = lo + w - 64'd1;
        end
        default: ;
      endcase
    end
    send_request(mode, lo, hi);
  endtask

  initial begin
    logic [63:0] mn;
    logic [63:0] mx;
    mn = 64'h8000000000000000;
    mx = 64'h7FFFFFFFFFFFFFFF;
    sb = new();
    cycles = 0;
    timed_out = 1'b0;
    sent = 0;
    steady = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = MODE_RAW;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    sb.load_seed(64'd0);
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed requests: every mode, field extremes and the bounded-mode corners.
    send_request(MODE_RAW, '0, '0);
    send_request(MODE_HI32, {64{1'b1}}, {64{1'b1}});
    send_request(MODE_FRAC, mn, mx);
    send_request(MODE_INT, mn, mx);
    send_request(MODE_INT, 64'd5, 64'd5);
    send_request(MODE_INT, mx, mx);
    send_request(MODE_INT, mn, mn);
    send_request(MODE_INT, 64'd6, 64'd5);
    send_request(MODE_INT, mx, mn);
    send_request(MODE_INT, 64'd0, 64'd15);
    send_request(MODE_INT, mn, 64'hFFFFFFFFFFFFFFFF);
    send_request(MODE_INT, 64'd0, mx);
    send_request(MODE_INT, 64'd0, 64'h8000000000000000 + 64'd2);
    send_request(MODE_INT, 64'hFFFFFFFFFFFFFFF0, 64'd9);
    send_request(MODE_INT, 64'd0, 64'd2);
    send_request(MODE_RAW, {64{1'b1}}, 64'd0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_seed({64{1'b1}});
        1: write_seed(64'd0);
        2: write_seed(64'h8000000000000000);
        default: write_seed(rand64());
      endcase
      steady = (ph == 2);
      for (int n = 0; n < 100; n++) begin
        random_request();
        if (n == 50 && ph == 3) drain();
      end
      drain();
    end
    steady = 1'b0;

    $display("covered %0d requests over six seeds, %0d results checked", sent, sb.checked);
    $display("all four modes, inverted bounds, single-value and full spans, rejection");
    if (sb.mismatches == 0 && sb.want_value.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mismatches, sb.want_value.size());
      $display("simulation failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/xrg_pkg.sv
rtl/core/xoshiro_random_generator_top.sv
rtl/core/xrg_checker.sv
sim/tb_xoshiro_random_generator_top.sv
